// ----- design/tile_sprite_compositor_core_macros.svh -----
// assertion macros for the tile sprite compositor
// no dependencies
`ifndef TILE_SPRITE_COMPOSITOR_CORE_MACROS_SVH
`define TILE_SPRITE_COMPOSITOR_CORE_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define TSC_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a condition implies a consequence in the next cycle
`define TSC_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ----- design/tsc_pkg.sv -----
// shared constants and functions of the tile sprite compositor
// no dependencies
package tsc_pkg;
    localparam logic [2:0] OP_VRAM    = 3'd0;
    localparam logic [2:0] OP_CRAM    = 3'd1;
    localparam logic [2:0] OP_APPEND  = 3'd2;
    localparam logic [2:0] OP_COMPOSE = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // 3-bit channel expanded to 8 bits, n*255/7
    function automatic logic [7:0] expand3(input logic [2:0] n);
        logic [7:0] r;
        begin
            case (n)
                3'd0: r = 8'd0;
                3'd1: r = 8'd36;
                3'd2: r = 8'd72;
                3'd3: r = 8'd109;
                3'd4: r = 8'd145;
                3'd5: r = 8'd182;
                3'd6: r = 8'd218;
                default: r = 8'd255;
            endcase
            expand3 = r;
        end
    endfunction

    // cell count clamp into 1..4, stored as count minus one
    function automatic logic [1:0] cells_m1(input logic [2:0] c);
        logic [1:0] r;
        begin
            if (c == 3'd0) r = 2'd0;
            else if (c > 3'd4) r = 2'd3;
            else r = 2'(c - 3'd1);
            cells_m1 = r;
        end
    endfunction
endpackage

// ----- design/tile_sprite_compositor_core.sv -----
// tile sprite compositor: loads and append pass exec and out states, a read adds a wait;
// compose reads each piece for the box, clears all MAX_SIDE*MAX_SIDE pixels, then takes
// each pixel through addr, vram, buf and write, a load per further piece, one vram port
// the next beat is accepted in the cycle after the result beat is taken
// rst_n (async, low) clears control, piece count and frame info; the image
// buffer is marked all transparent through a per-compose clearing pass
`include "tile_sprite_compositor_core_macros.svh"
module tile_sprite_compositor_core
    import tsc_pkg::*;
#(
    parameter int MAX_SIDE   = 128,
    parameter int MAX_PIECES = 80
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], address[18:3], data[34:19], piece_x[44:35], piece_y[54:45],
    // piece_w_cells[57:55], piece_h_cells[60:58], piece_attr[76:61], mirror[77]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24], width[39:32],
    // height[47:40], anchor_x[58:48], anchor_y[69:59], piece_count[76:70],
    // used_mask[92:77], status[94:93]
    output logic [95:0] m_axis_tdata
);
    localparam int PIX   = MAX_SIDE * MAX_SIDE;
    localparam int PW    = $clog2(PIX);
    localparam int PIW   = $clog2(MAX_PIECES);
    localparam int PIWA  = (PIW < 1) ? 1 : PIW;
    localparam int CW    = $clog2(MAX_PIECES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_BOX_RD, S_BOX, S_CHECK, S_CLEAR, S_PX_LOAD,
        S_PX_ADDR, S_PX_VRAM, S_PX_BUF, S_PX_WRITE, S_RD_WAIT, S_OUT
    } state_t;

    // storage
    logic [7:0]  vram [65536];
    logic [8:0]  cram [64];
    logic [39:0] plist [MAX_PIECES];
    logic [24:0] ibuf [PIX];

    state_t       state_reg;
    logic [79:0]  in_reg;
    logic [CW-1:0] total_reg;
    logic [CW-1:0] idx_reg;
    logic [39:0]  prd_reg;
    logic signed [11:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [9:0]   w_reg, h_reg;
    logic [PW:0]  clr_reg;
    logic [4:0]   px_reg, py_reg;
    logic [15:0]  vaddr_reg;
    logic [7:0]   vbyte_reg;
    logic [24:0]  bufrd_reg;
    logic [24:0]  bufpix_reg;
    logic [8:0]   cword_reg;
    logic [PW-1:0] pos_reg;
    logic         odd_reg;
    logic [15:0]  used_reg;
    logic         any_reg;
    logic [1:0]   status_reg;
    logic [24:0]  pix_reg;
    logic [7:0]   fw_reg, fh_reg;
    logic [10:0]  fax_reg, fay_reg;
    logic [6:0]   fpc_reg;
    logic [15:0]  fused_reg;

    // input fields
    logic [2:0]  op;
    logic [15:0] address, data;
    assign op      = in_reg[2:0];
    assign address = in_reg[18:3];
    assign data    = in_reg[34:19];

    // current piece fields
    logic signed [11:0] pc_x, pc_y;
    logic [1:0]  pc_wm, pc_hm;
    logic [15:0] pc_attr;
    assign pc_x    = 12'(signed'(prd_reg[9:0]));
    assign pc_y    = 12'(signed'(prd_reg[19:10]));
    assign pc_wm   = prd_reg[21:20];
    assign pc_hm   = prd_reg[23:22];
    assign pc_attr = prd_reg[39:24];

    logic [5:0] pw_pix, ph_pix;
    assign pw_pix = {1'b0, pc_wm, 3'b000} + 6'd8;
    assign ph_pix = {1'b0, pc_hm, 3'b000} + 6'd8;

    // tile address of the current pixel
    logic [4:0]  sx, sy;
    logic [15:0] tile_addr;
    logic [2:0]  hc;
    always_comb
    begin
        sx = pc_attr[11] ? 5'(pw_pix - 6'd1 - {1'b0, px_reg}) : px_reg;
        sy = pc_attr[12] ? 5'(ph_pix - 6'd1 - {1'b0, py_reg}) : py_reg;
        hc = {1'b0, pc_hm} + 3'd1;
        tile_addr = 16'(({5'd0, pc_attr[10:0]} + 16'(sx[4:3] * hc) + {14'd0, sy[4:3]})
                    * 16'd32 + {11'd0, sy[2:0], 2'b00} + {14'd0, sx[2:1]});
    end

    // image position of the current pixel
    logic signed [11:0] ix, iy;
    logic [PW-1:0] pos_c;
    always_comb
    begin
        ix = pc_x + 12'(px_reg) - x0_reg;
        iy = pc_y + 12'(py_reg) - y0_reg;
        if (in_reg[77]) ix = 12'(w_reg) - 12'sd1 - ix;
        pos_c = PW'(iy * 12'(w_reg) + ix);
    end

    logic [3:0] nib;
    assign nib = odd_reg ? vbyte_reg[3:0] : vbyte_reg[7:4];

    logic signed [11:0] pr, pb;
    assign pr = pc_x + 12'(pw_pix);
    assign pb = pc_y + 12'(ph_pix);

    logic [31:0] area;
    assign area = 32'(fw_reg) * 32'(fh_reg);

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && op == OP_VRAM) vram[address] <= data[7:0];
        if (state_reg == S_EXEC && op == OP_CRAM)
            cram[address[5:0]] <= {data[11:9], data[7:5], data[3:1]};
        if (state_reg == S_EXEC && op == OP_APPEND && total_reg < CW'(MAX_PIECES))
            plist[PIWA'(total_reg)] <= {in_reg[76:61], cells_m1(in_reg[60:58]),
                                        cells_m1(in_reg[57:55]), in_reg[54:35]};
        prd_reg    <= plist[PIWA'(idx_reg)];
        vbyte_reg  <= vram[vaddr_reg];
        cword_reg  <= cram[{pc_attr[14:13], nib}];
        bufrd_reg  <= ibuf[pos_c];
        bufpix_reg <= ibuf[PW'(address)];
        if (state_reg == S_CLEAR) ibuf[PW'(clr_reg)] <= 25'd0;
        if (state_reg == S_PX_WRITE && nib != 4'd0 && !bufrd_reg[24])
            ibuf[pos_reg] <= {1'b1, expand3(cword_reg[8:6]), expand3(cword_reg[5:3]),
                              expand3(cword_reg[2:0])};
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            total_reg  <= '0;
            fw_reg     <= '0;
            fh_reg     <= '0;
            fax_reg    <= '0;
            fay_reg    <= '0;
            fpc_reg    <= '0;
            fused_reg  <= '0;
            status_reg <= ST_OK;
            idx_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        in_reg <= s_axis_tdata;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    status_reg <= ST_OK;
                    idx_reg <= '0;
                    x0_reg <= 12'sh7FF; y0_reg <= 12'sh7FF;
                    x1_reg <= -12'sd2048; y1_reg <= -12'sd2048;
                    case (op)
                        OP_APPEND:
                        begin
                            if (total_reg < CW'(MAX_PIECES)) total_reg <= total_reg + 1'b1;
                            else status_reg <= ST_REJECT;
                            state_reg <= S_OUT;
                        end
                        OP_COMPOSE:
                        begin
                            if (total_reg == '0)
                            begin
                                status_reg <= ST_REJECT;
                                state_reg <= S_OUT;
                            end
                            else state_reg <= S_BOX_RD;
                        end
                        OP_READ: state_reg <= S_RD_WAIT;
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_RD_WAIT:
                begin
                    pix_reg <= (32'(address) >= area) ? '0 : bufpix_reg;
                    state_reg <= S_OUT;
                end
                S_BOX_RD: state_reg <= S_BOX;
                S_BOX:
                begin
                    if (pc_x < x0_reg) x0_reg <= pc_x;
                    if (pc_y < y0_reg) y0_reg <= pc_y;
                    if (pr > x1_reg) x1_reg <= pr;
                    if (pb > y1_reg) y1_reg <= pb;
                    if (idx_reg + 1'b1 == total_reg) state_reg <= S_CHECK;
                    else state_reg <= S_BOX_RD;
                    idx_reg <= idx_reg + 1'b1;
                end
                S_CHECK:
                begin
                    w_reg <= 10'(x1_reg - x0_reg);
                    h_reg <= 10'(y1_reg - y0_reg);
                    idx_reg <= '0;
                    clr_reg <= '0;
                    used_reg <= '0;
                    any_reg <= 1'b0;
                    px_reg <= '0;
                    py_reg <= '0;
                    if (x1_reg - x0_reg > 12'(MAX_SIDE) || y1_reg - y0_reg > 12'(MAX_SIDE))
                    begin
                        status_reg <= ST_REJECT;
                        total_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else state_reg <= S_CLEAR;
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (PW+1)'(PIX - 1)) state_reg <= S_PX_ADDR;
                end
                S_PX_LOAD: state_reg <= S_PX_ADDR;
                S_PX_ADDR:
                begin
                    vaddr_reg <= tile_addr;
                    odd_reg <= sx[0];
                    state_reg <= S_PX_VRAM;
                end
                S_PX_VRAM:
                begin
                    pos_reg <= pos_c;
                    state_reg <= S_PX_BUF;
                end
                S_PX_BUF: state_reg <= S_PX_WRITE;
                S_PX_WRITE:
                begin
                    if (nib != 4'd0 && !bufrd_reg[24])
                    begin
                        used_reg[nib] <= 1'b1;
                        any_reg <= 1'b1;
                    end
                    state_reg <= S_PX_ADDR;
                    if ({1'b0, px_reg} + 6'd1 == pw_pix)
                    begin
                        px_reg <= '0;
                        if ({1'b0, py_reg} + 6'd1 == ph_pix)
                        begin
                            py_reg <= '0;
                            idx_reg <= idx_reg + 1'b1;
                            if (idx_reg + 1'b1 == total_reg)
                            begin
                                fw_reg <= 8'(w_reg);
                                fh_reg <= 8'(h_reg);
                                fax_reg <= in_reg[77] ? 11'(12'(w_reg) + x0_reg)
                                                      : 11'(-x0_reg);
                                fay_reg <= 11'(-y0_reg);
                                fpc_reg <= 7'(total_reg);
                                fused_reg <= used_reg | (16'((nib != 4'd0 &&
                                             !bufrd_reg[24])) << nib);
                                status_reg <= (any_reg || (nib != 4'd0 && !bufrd_reg[24]))
                                              ? ST_OK : ST_EMPTY;
                                total_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            else state_reg <= S_PX_LOAD;
                        end
                        else py_reg <= py_reg + 1'b1;
                    end
                    else px_reg <= px_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (m_axis_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // piece read during drawing needs an extra read state, S_PX_LOAD; prd_reg is
    // loaded every cycle so S_CLEAR and S_PX_LOAD leave it settled
    logic rd_op;
    assign rd_op = (op == OP_READ);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {1'b0, status_reg, fused_reg, fpc_reg, fay_reg, fax_reg,
                           fh_reg, fw_reg,
                           (rd_op && pix_reg[24]) ? 8'd255 : 8'd0,
                           rd_op ? pix_reg[23:0] : 24'd0};

    `TSC_ASSERT_IMP(a_one_side, m_axis_tvalid, !s_axis_tready)
    `TSC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TSC_ASSERT_IMP(a_total_range, 1'b1, total_reg <= CW'(MAX_PIECES))
endmodule
